// ===== hdl/sm3_pkg.sv =====
// sm3 hash engine package: constants, types and round functions
// depends on nothing
package sm3_pkg;

  localparam logic [31:0] Iv [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;
  localparam logic [31:0] PadWord = 32'h80000000;

  typedef enum logic [2:0] {
    WsZero = 3'd0,
    WsData = 3'd1,
    WsLenHi = 3'd2,
    WsLenLo = 3'd3,
    WsPad = 3'd4
  } wsel_t;

  typedef struct packed {
    logic       store;
    wsel_t      wsel;
    logic       init;
    logic       round;
    logic       fold;
    logic       iv_load;
    logic       len_add;
    logic       len_clr;
  } sm3_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic [5:0] round_idx;
  } sm3_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== hdl/sm3_if.sv =====
// valid/ready channel interface for input and digest transactions
// depends on nothing
interface sm3_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source (output valid, message_word, byte_count, last_word, input ready);
  modport sink (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sm3_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_done;
  modport source (output valid, digest_word, word_index, digest_done, input ready);
  modport sink (input valid, digest_word, word_index, digest_done, output ready);
endinterface

// ===== hdl/sm3_hash_engine_unit.sv =====
// sm3 hash engine top level
// depends on sm3_pkg, sm3_if, sm3_ctrl, sm3_datapath
// Message words are taken one per cycle until a 16-word block fills; the block
// is then compressed by a single shared round unit (load, 64 rounds, fold),
// during which no word is accepted. A last word adds the padding words one
// per cycle, one or two compressions, and then eight digest transactions,
// word 0 first.
module sm3_hash_engine_unit (
  input logic clk,
  input logic rst,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  sm3_pkg::sm3_cmd_t cmd;
  sm3_pkg::sm3_sts_t sts;
  logic [31:0] data_word;
  logic [5:0]  add_bits;
  logic [2:0]  idx;

  sm3_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_word(in_ch.message_word), .in_count(in_ch.byte_count),
    .in_last(in_ch.last_word),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_idx(idx),
    .cmd(cmd), .data_word(data_word), .add_bits(add_bits), .sts(sts)
  );

  sm3_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_word(data_word),
    .add_bits(add_bits), .out_sel(idx), .out_word(out_ch.digest_word), .sts(sts)
  );

  assign out_ch.word_index = idx;
  assign out_ch.digest_done = (idx == 3'd7);

endmodule

// ===== hdl/sm3_datapath.sv =====
// sm3 datapath: block buffer, message expansion window, round unit, chain value
// depends on sm3_pkg
module sm3_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sm3_pkg::sm3_cmd_t   cmd,
  input  logic [31:0]         data_word,
  input  logic [5:0]          add_bits,
  input  logic [2:0]          out_sel,
  output logic [31:0]         out_word,
  output sm3_pkg::sm3_sts_t   sts
);

  logic [31:0] block [16];
  logic [31:0] win [16];
  logic [31:0] v [8];
  logic [31:0] r [8];
  logic [63:0] bit_total;
  logic [3:0]  fill;
  logic [5:0]  ridx;
  logic [31:0] wr_word;
  logic [31:0] w_new;
  logic [31:0] t_rot, a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    unique case (cmd.wsel)
      sm3_pkg::WsData:  wr_word = data_word;
      sm3_pkg::WsLenHi: wr_word = bit_total[63:32];
      sm3_pkg::WsLenLo: wr_word = bit_total[31:0];
      sm3_pkg::WsPad:   wr_word = sm3_pkg::PadWord;
      default:          wr_word = '0;
    endcase
  end

  always_comb begin
    w_new = sm3_pkg::p1(win[0] ^ win[7] ^ sm3_pkg::rotl(win[13], 5'd15))
          ^ sm3_pkg::rotl(win[3], 5'd7) ^ win[10];
    t_rot = sm3_pkg::rotl((ridx < 6'd16) ? sm3_pkg::TLow : sm3_pkg::THigh, ridx[4:0]);
    a12 = sm3_pkg::rotl(r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r[4] + t_rot, 5'd7);
    ss2 = ss1 ^ a12;
    if (ridx < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + r[7] + ss1 + win[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.store) block[fill] <= wr_word;
    if (cmd.init) begin
      for (int i = 0; i < 16; i++) win[i] <= block[i];
      for (int i = 0; i < 8; i++) r[i] <= v[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_new;
      r[0] <= tt1;
      r[1] <= r[0];
      r[2] <= sm3_pkg::rotl(r[1], 5'd9);
      r[3] <= r[2];
      r[4] <= sm3_pkg::p0(tt2);
      r[5] <= r[4];
      r[6] <= sm3_pkg::rotl(r[5], 5'd19);
      r[7] <= r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ridx <= '0;
      bit_total <= '0;
      for (int i = 0; i < 8; i++) v[i] <= sm3_pkg::Iv[i];
    end else begin
      if (cmd.store) fill <= fill + 4'd1;
      if (cmd.init) ridx <= '0;
      else if (cmd.round) ridx <= ridx + 6'd1;
      if (cmd.len_clr) bit_total <= '0;
      else if (cmd.len_add) bit_total <= bit_total + {58'd0, add_bits};
      if (cmd.iv_load) begin
        for (int i = 0; i < 8; i++) v[i] <= sm3_pkg::Iv[i];
      end else if (cmd.fold) begin
        for (int i = 0; i < 8; i++) v[i] <= v[i] ^ r[i];
      end
    end
  end

  assign out_word = v[out_sel];
  assign sts.fill = fill;
  assign sts.round_idx = ridx;

endmodule

// ===== hdl/sm3_ctrl.sv =====
// sm3 controller: accepts words, sequences padding, compression and digest output
// depends on sm3_pkg
module sm3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_word,
  input  logic [2:0]          in_count,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_idx,
  output sm3_pkg::sm3_cmd_t   cmd,
  output logic [31:0]         data_word,
  output logic [5:0]          add_bits,
  input  sm3_pkg::sm3_sts_t   sts
);

  typedef enum logic [6:0] {
    Idle  = 7'b0000001,
    Init  = 7'b0000010,
    Round = 7'b0000100,
    Fold  = 7'b0001000,
    Pad   = 7'b0010000,
    Emit  = 7'b0100000,
    Clear = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic finishing, finishing_next;
  logic need_pad80, need_pad80_next;
  logic [2:0] idx, idx_next;
  logic [2:0] cnt;
  logic [31:0] keep, padded;
  logic accept;

  always_comb begin
    cnt = (in_count > 3'd4) ? 3'd4 : in_count;
    unique case (cnt)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'hFF000000;
      3'd2: keep = 32'hFFFF0000;
      3'd3: keep = 32'hFFFFFF00;
      default: keep = 32'hFFFFFFFF;
    endcase
    unique case (cnt)
      3'd0: padded = 32'h80000000;
      3'd1: padded = (in_word & keep) | 32'h00800000;
      3'd2: padded = (in_word & keep) | 32'h00008000;
      3'd3: padded = (in_word & keep) | 32'h00000080;
      default: padded = in_word;
    endcase
  end

  assign in_ready = (state == Idle);
  assign accept = in_valid && in_ready;
  assign out_valid = (state == Emit);
  assign out_idx = idx;
  assign data_word = in_last ? padded : in_word;

  always_comb begin
    state_next = state;
    finishing_next = finishing;
    need_pad80_next = need_pad80;
    idx_next = idx;
    cmd = '0;
    cmd.wsel = sm3_pkg::WsZero;
    add_bits = '0;
    unique case (state)
      Idle: begin
        if (accept) begin
          cmd.store = 1'b1;
          cmd.wsel = sm3_pkg::WsData;
          cmd.len_add = 1'b1;
          if (!in_last) begin
            add_bits = 6'd32;
            if (sts.fill == 4'd15) state_next = Init;
          end else begin
            add_bits = {cnt, 3'b000};
            finishing_next = 1'b1;
            need_pad80_next = (cnt == 3'd4);
            if (sts.fill == 4'd15) state_next = Init;
            else state_next = Pad;
          end
        end
      end
      Init: begin
        cmd.init = 1'b1;
        state_next = Round;
      end
      Round: begin
        cmd.round = 1'b1;
        if (sts.round_idx == 6'd63) state_next = Fold;
      end
      Fold: begin
        cmd.fold = 1'b1;
        if (finishing) state_next = Pad;
        else state_next = Idle;
      end
      Pad: begin
        cmd.store = 1'b1;
        if (need_pad80) begin
          cmd.wsel = sm3_pkg::WsPad;
          need_pad80_next = 1'b0;
          if (sts.fill == 4'd15) state_next = Init;
        end else if (sts.fill == 4'd14) begin
          cmd.wsel = sm3_pkg::WsLenHi;
          idx_next = 3'd2;
        end else if (sts.fill == 4'd15) begin
          if (idx == 3'd2 && finishing) begin
            cmd.wsel = sm3_pkg::WsLenLo;
            idx_next = 3'd1;
          end
          state_next = Init;
        end else begin
          cmd.wsel = sm3_pkg::WsZero;
        end
      end
      Emit: begin
        if (out_ready) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) state_next = Clear;
        end
      end
      Clear: begin
        cmd.iv_load = 1'b1;
        cmd.len_clr = 1'b1;
        finishing_next = 1'b0;
        state_next = Idle;
      end
      default: state_next = Idle;
    endcase
    // after the length block fold, move to output
    if (state == Fold && finishing && idx == 3'd1) begin
      state_next = Emit;
      idx_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      finishing <= 1'b0;
      need_pad80 <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      finishing <= finishing_next;
      need_pad80 <= need_pad80_next;
      idx <= idx_next;
    end
  end

endmodule

// ===== hdl/sm3_checker.sv =====
// port-level checker for the sm3 hash engine, bound to the top level
// depends on sm3_hash_engine_unit
module sm3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       digest_done
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken during digest output");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digest_done == (word_index == 3'd7))) else $error("done flag mismatch");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !digest_done) |=> (out_valid &&
      word_index == $past(word_index) + 3'd1)) else $error("digest index skipped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
    else $error("digest transaction dropped");

endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.word_index), .digest_done(out_ch.digest_done)
);
